FILE: design/csfp_pkg.sv
// Shared types and constants for the clock synthesizer frequency planner.
`default_nettype none
package csfp_pkg;

   localparam int DivDividendW = 46;
   localparam int DivDivisorW  = 28;
   localparam int DivStepsW    = 6;

   localparam logic [29:0] VCO_TARGET = 30'd900000000;
   localparam logic [19:0] FRAC_DEN   = 20'hFFFFF;
   localparam logic [29:0] MAX_DIV    = 30'd300;
   localparam logic [29:0] MIN_DIV    = 30'd6;
   localparam logic [17:0] PLL_OFFSET = 18'd512;
   localparam logic [15:0] MS_OFFSET  = 16'd512;
   localparam logic [7:0]  CTRL_ON    = 8'h4C;
   localparam logic [7:0]  CTRL_OFF   = 8'h80;
   localparam logic [25:0] XTAL_RESET = 26'd25000000;

   localparam logic [DivStepsW-1:0] STEPS_VCO  = 6'd30;
   localparam logic [DivStepsW-1:0] STEPS_MULT = 6'd30;
   localparam logic [DivStepsW-1:0] STEPS_NUM  = 6'd46;
   localparam logic [DivStepsW-1:0] STEPS_FRAC = 6'd27;

   localparam logic CSR_XTAL  = 1'b0;
   localparam logic CSR_DRIVE = 1'b1;

   typedef struct packed {
      logic                 start;
      logic [DivStepsW-1:0] steps;
   } div_ctrl_type;

endpackage
`default_nettype wire

FILE: design/clock_synth_frequency_planner.sv
// Top level: request sequencer, shared serial divider and multiplier, result register.
// A new target frequency is planned with four serial divisions through one shared
// restoring divider (30, 30, 46 and 27 steps), a 9-step serial multiply and up to
// 22 halving steps. An unchanged or zero request goes straight to the finish
// state, a target too high for the minimum divider stops after the first
// division, and a zero crystal register skips the three ratio divisions. The
// divider is the limiting unit. One request is worked at a time; the next is taken
// while the previous result waits on rsp_.
`default_nettype none
module clock_synth_frequency_planner (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [27:0] req_target_freq,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_freq_changed,
   output logic             rsp_out_enabled,
   output logic             rsp_pll_written,
   output logic [17:0]      rsp_pll_p1,
   output logic [19:0]      rsp_pll_p2,
   output logic             rsp_ms_written,
   output logic [15:0]      rsp_ms_p1,
   output logic [4:0]       rsp_r_div,
   output logic             rsp_ctrl_written,
   output logic [7:0]       rsp_ctrl_byte,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [25:0] csr_write_data
);
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DIV0   = 9'b000000010,
      ST_HALVE  = 9'b000000100,
      ST_MUL    = 9'b000001000,
      ST_DIV1   = 9'b000010000,
      ST_DIV2   = 9'b000100000,
      ST_DIV3   = 9'b001000000,
      ST_MSCHK  = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type state_ff;

   logic [25:0] xtal_ff;
   logic [1:0]  drive_ff;
   logic [27:0] last_freq_ff;
   logic [8:0]  last_div_ff;
   logic [4:0]  last_r_ff;

   logic [27:0] freq_ff;
   logic [29:0] work_div_ff;
   logic [29:0] fsh_ff;
   logic [4:0]  r_ff;
   logic [10:0] mult_lo_ff;

   logic                               div_start_ff;
   logic [csfp_pkg::DivStepsW-1:0]     div_steps_ff;
   logic [csfp_pkg::DivDividendW-1:0]  div_dividend_ff;
   logic [csfp_pkg::DivDivisorW-1:0]   div_divisor_ff;
   csfp_pkg::div_ctrl_type             div_ctrl;
   logic                               div_done;
   logic [csfp_pkg::DivDividendW-1:0]  div_quot;
   logic [csfp_pkg::DivDivisorW-1:0]   div_rem;

   logic        mul_start_ff;
   logic [8:0]  mul_a_ff;
   logic [29:0] mul_b_ff;
   logic        mul_done;
   logic [29:0] mul_prod;

   // result being built
   logic        res_changed_ff, res_enabled_ff, res_pll_w_ff, res_ms_w_ff, res_ctrl_w_ff;
   logic [17:0] res_p1_ff;
   logic [19:0] res_p2_ff;
   logic [15:0] res_ms_p1_ff;
   logic [4:0]  res_r_ff;
   logic [7:0]  res_ctrl_ff;

   // output register
   logic        rsp_valid_ff;
   logic        out_changed_ff, out_enabled_ff, out_pll_w_ff, out_ms_w_ff, out_ctrl_w_ff;
   logic [17:0] out_p1_ff;
   logic [19:0] out_p2_ff;
   logic [15:0] out_ms_p1_ff;
   logic [4:0]  out_r_ff;
   logic [7:0]  out_ctrl_ff;

   logic [45:0] num_dividend;

   assign div_ctrl.start = div_start_ff;
   assign div_ctrl.steps = div_steps_ff;
   // rem * 0xFFFFF as (rem << 20) - rem
   assign num_dividend = {div_rem[25:0], 20'b0} - {20'b0, div_rem[25:0]};

   csfp_serial_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (div_dividend_ff),
      .divisor   (div_divisor_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   csfp_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .mplier  (mul_a_ff),
      .mcand   (mul_b_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         xtal_ff      <= csfp_pkg::XTAL_RESET;
         drive_ff     <= '0;
         last_freq_ff <= '0;
         last_div_ff  <= '0;
         last_r_ff    <= '0;
         div_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;

         if (csr_write_enable) begin
            unique case (csr_index)
               csfp_pkg::CSR_XTAL:  xtal_ff  <= csr_write_data;
               csfp_pkg::CSR_DRIVE: drive_ff <= csr_write_data[1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  freq_ff        <= req_target_freq;
                  res_changed_ff <= 1'b0;
                  res_enabled_ff <= 1'b0;
                  res_pll_w_ff   <= 1'b0;
                  res_p1_ff      <= '0;
                  res_p2_ff      <= '0;
                  res_ms_w_ff    <= 1'b0;
                  res_ms_p1_ff   <= '0;
                  res_r_ff       <= '0;
                  res_ctrl_w_ff  <= 1'b0;
                  res_ctrl_ff    <= '0;
                  if (req_target_freq == last_freq_ff) begin
                     res_enabled_ff <= (last_div_ff != 9'd0);
                     state_ff       <= ST_FINISH;
                  end else begin
                     last_freq_ff   <= req_target_freq;
                     res_changed_ff <= 1'b1;
                     if (req_target_freq == 28'd0) begin
                        last_div_ff   <= '0;
                        res_ctrl_w_ff <= 1'b1;
                        res_ctrl_ff   <= csfp_pkg::CTRL_OFF;
                        state_ff      <= ST_FINISH;
                     end else begin
                        div_start_ff    <= 1'b1;
                        div_steps_ff    <= csfp_pkg::STEPS_VCO;
                        div_dividend_ff <= {16'b0, csfp_pkg::VCO_TARGET};
                        div_divisor_ff  <= req_target_freq;
                        state_ff        <= ST_DIV0;
                     end
                  end
               end
            end
            ST_DIV0: begin
               if (div_done) begin
                  if (div_quot[29:0] < csfp_pkg::MIN_DIV) begin
                     last_div_ff   <= '0;
                     res_ctrl_w_ff <= 1'b1;
                     res_ctrl_ff   <= csfp_pkg::CTRL_OFF;
                     state_ff      <= ST_FINISH;
                  end else begin
                     work_div_ff <= div_quot[29:0];
                     fsh_ff      <= {2'b0, freq_ff};
                     r_ff        <= '0;
                     state_ff    <= ST_HALVE;
                  end
               end
            end
            ST_HALVE: begin
               if (work_div_ff > csfp_pkg::MAX_DIV) begin
                  work_div_ff <= {1'b0, work_div_ff[29:1]};
                  fsh_ff      <= {fsh_ff[28:0], 1'b0};
                  r_ff        <= r_ff + 5'd1;
               end else begin
                  // no halving: force the divider even
                  work_div_ff[0] <= work_div_ff[0] & (r_ff != 5'd0);
                  mul_a_ff       <= {work_div_ff[8:1], work_div_ff[0] & (r_ff != 5'd0)};
                  mul_b_ff       <= fsh_ff;
                  mul_start_ff   <= 1'b1;
                  state_ff       <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (mul_done) begin
                  res_enabled_ff <= 1'b1;
                  if (xtal_ff != 26'd0) begin
                     div_start_ff    <= 1'b1;
                     div_steps_ff    <= csfp_pkg::STEPS_MULT;
                     div_dividend_ff <= {16'b0, mul_prod};
                     div_divisor_ff  <= {2'b0, xtal_ff};
                     state_ff        <= ST_DIV1;
                  end else begin
                     state_ff <= ST_MSCHK;
                  end
               end
            end
            ST_DIV1: begin
               if (div_done) begin
                  mult_lo_ff      <= div_quot[10:0];
                  div_start_ff    <= 1'b1;
                  div_steps_ff    <= csfp_pkg::STEPS_NUM;
                  div_dividend_ff <= num_dividend;
                  div_divisor_ff  <= {2'b0, xtal_ff};
                  state_ff        <= ST_DIV2;
               end
            end
            ST_DIV2: begin
               if (div_done) begin
                  div_start_ff    <= 1'b1;
                  div_steps_ff    <= csfp_pkg::STEPS_FRAC;
                  div_dividend_ff <= {19'b0, div_quot[19:0], 7'b0};
                  div_divisor_ff  <= {8'b0, csfp_pkg::FRAC_DEN};
                  state_ff        <= ST_DIV3;
               end
            end
            ST_DIV3: begin
               if (div_done) begin
                  // quotient is the fraction floor, remainder is P2
                  res_pll_w_ff <= 1'b1;
                  res_p1_ff    <= {mult_lo_ff, 7'b0} + {11'b0, div_quot[6:0]}
                                  - csfp_pkg::PLL_OFFSET;
                  res_p2_ff    <= div_rem[19:0];
                  state_ff     <= ST_MSCHK;
               end
            end
            ST_MSCHK: begin
               if (work_div_ff[8:0] != last_div_ff || r_ff != last_r_ff) begin
                  res_ms_w_ff   <= 1'b1;
                  res_ms_p1_ff  <= {work_div_ff[8:0], 7'b0} - csfp_pkg::MS_OFFSET;
                  res_r_ff      <= r_ff;
                  res_ctrl_w_ff <= 1'b1;
                  res_ctrl_ff   <= csfp_pkg::CTRL_ON | {6'b0, drive_ff};
                  last_div_ff   <= work_div_ff[8:0];
                  last_r_ff     <= r_ff;
               end
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  out_changed_ff <= res_changed_ff;
                  out_enabled_ff <= res_enabled_ff;
                  out_pll_w_ff   <= res_pll_w_ff;
                  out_p1_ff      <= res_p1_ff;
                  out_p2_ff      <= res_p2_ff;
                  out_ms_w_ff    <= res_ms_w_ff;
                  out_ms_p1_ff   <= res_ms_p1_ff;
                  out_r_ff       <= res_r_ff;
                  out_ctrl_w_ff  <= res_ctrl_w_ff;
                  out_ctrl_ff    <= res_ctrl_ff;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_freq_changed = out_changed_ff;
   assign rsp_out_enabled  = out_enabled_ff;
   assign rsp_pll_written  = out_pll_w_ff;
   assign rsp_pll_p1       = out_p1_ff;
   assign rsp_pll_p2       = out_p2_ff;
   assign rsp_ms_written   = out_ms_w_ff;
   assign rsp_ms_p1        = out_ms_p1_ff;
   assign rsp_r_div        = out_r_ff;
   assign rsp_ctrl_written = out_ctrl_w_ff;
   assign rsp_ctrl_byte    = out_ctrl_ff;
endmodule
`default_nettype wire

FILE: design/csfp_serial_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module csfp_serial_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire csfp_pkg::div_ctrl_type             ctrl,
   input  wire logic [csfp_pkg::DivDividendW-1:0]  dividend,
   input  wire logic [csfp_pkg::DivDivisorW-1:0]   divisor,
   output logic                                    done,
   output logic [csfp_pkg::DivDividendW-1:0]       quotient,
   output logic [csfp_pkg::DivDivisorW-1:0]        remainder
);
   logic [csfp_pkg::DivDividendW-1:0] dq_ff;
   logic [csfp_pkg::DivDivisorW-1:0]  rem_ff;
   logic [csfp_pkg::DivDivisorW-1:0]  dsr_ff;
   logic [csfp_pkg::DivStepsW-1:0]    cnt_ff;
   logic                              busy_ff;
   logic                              done_ff;
   logic [csfp_pkg::DivDivisorW+1:0]  trial;
   logic [csfp_pkg::DivStepsW-1:0]    align;

   assign align = 6'd46 - ctrl.steps;
   assign trial = {1'b0, rem_ff, dq_ff[csfp_pkg::DivDividendW-1]} - {2'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            // dividend left-aligned so its top bit leads
            dq_ff   <= dividend << align;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
            cnt_ff  <= ctrl.steps;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!trial[csfp_pkg::DivDivisorW+1]) begin
               rem_ff <= trial[csfp_pkg::DivDivisorW-1:0];
               dq_ff  <= {dq_ff[csfp_pkg::DivDividendW-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[csfp_pkg::DivDivisorW-2:0],
                          dq_ff[csfp_pkg::DivDividendW-1]};
               dq_ff  <= {dq_ff[csfp_pkg::DivDividendW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

FILE: design/csfp_serial_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, product mod 2^30.
`default_nettype none
module csfp_serial_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [8:0]  mplier,
   input  wire logic [29:0] mcand,
   output logic             done,
   output logic [29:0]      product
);
   logic [8:0]  mplier_ff;
   logic [29:0] mcand_ff;
   logic [29:0] acc_ff;
   logic [3:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            mplier_ff <= mplier;
            mcand_ff  <= mcand;
            acc_ff    <= '0;
            cnt_ff    <= 4'd9;
            busy_ff   <= 1'b1;
         end else if (busy_ff) begin
            if (mplier_ff[0])
               acc_ff <= acc_ff + mcand_ff;
            mplier_ff <= {1'b0, mplier_ff[8:1]};
            mcand_ff  <= {mcand_ff[28:0], 1'b0};
            cnt_ff    <= cnt_ff - 4'd1;
            if (cnt_ff == 4'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

FILE: test/tb_clock_synth_frequency_planner.sv
// Testbench for the clock synthesizer frequency planner: random and directed requests.
`default_nettype none
module tb_clock_synth_frequency_planner;

   localparam int CycleLimit = 1500000;

   typedef struct packed {
      logic        freq_changed;
      logic        out_enabled;
      logic        pll_written;
      logic [17:0] pll_p1;
      logic [19:0] pll_p2;
      logic        ms_written;
      logic [15:0] ms_p1;
      logic [4:0]  r_div;
      logic        ctrl_written;
      logic [7:0]  ctrl_byte;
   } plan_type;

   class plan_scoreboard;
      plan_type    pending_plans[$];
      logic [25:0] xtal_hz;
      logic [1:0]  drive_bits;
      logic [27:0] last_freq;
      logic [8:0]  last_divider;
      logic [4:0]  last_rdiv;
      int          mismatches;
      int          plans_checked;

      function new();
         xtal_hz      = csfp_pkg::XTAL_RESET;
         drive_bits   = '0;
         last_freq    = '0;
         last_divider = '0;
         last_rdiv    = '0;
         mismatches   = 0;
         plans_checked = 0;
      endfunction

      function void write_reg(logic index, logic [25:0] data);
         if (index == csfp_pkg::CSR_XTAL) xtal_hz = data;
         else drive_bits = data[1:0];
      endfunction

      task report(string msg);
         $display("mismatch @%0t: %s", $realtime, msg);
         mismatches++;
      endtask

      // plan one request and queue the beat it should produce
      function void note_request(logic [27:0] freq);
         plan_type         p;
         logic [31:0]      divider;
         logic [4:0]       halvings;
         logic [63:0]      vco_hz, mult, rem, num, t, p1w, p2w;
         p = '0;
         halvings = '0;
         if (freq == last_freq) begin
            p.out_enabled = last_divider != 0;
         end else begin
            last_freq = freq;
            p.freq_changed = 1'b1;
            divider = (freq == 0) ? 32'd0 : 32'd900000000 / {4'd0, freq};
            if (divider < 6) begin
               last_divider = '0;
               p.ctrl_written = 1'b1;
               p.ctrl_byte = csfp_pkg::CTRL_OFF;
            end else begin
               while (divider > 300) begin
                  halvings++;
                  divider = divider >> 1;
               end
               if (halvings == 0) divider[0] = 1'b0;
               p.out_enabled = 1'b1;
               vco_hz = (64'(divider) * 64'(freq)) << halvings;
               if (xtal_hz != 0) begin
                  mult = vco_hz / 64'(xtal_hz);
                  rem  = vco_hz - mult * 64'(xtal_hz);
                  num  = rem * 64'(csfp_pkg::FRAC_DEN) / 64'(xtal_hz);
                  t    = (64'd128 * num) / 64'(csfp_pkg::FRAC_DEN);
                  p1w  = 64'd128 * mult + t - 64'd512;
                  p2w  = 64'd128 * num - 64'(csfp_pkg::FRAC_DEN) * t;
                  p.pll_written = 1'b1;
                  p.pll_p1 = p1w[17:0];
                  p.pll_p2 = p2w[19:0];
               end
               if (divider[8:0] != last_divider || halvings != last_rdiv) begin
                  p.ms_written   = 1'b1;
                  p.ms_p1        = 16'(divider * 128 - 512);
                  p.r_div        = halvings;
                  p.ctrl_written = 1'b1;
                  p.ctrl_byte    = csfp_pkg::CTRL_ON | {6'd0, drive_bits};
                  last_divider   = divider[8:0];
                  last_rdiv      = halvings;
               end
            end
         end
         pending_plans.push_back(p);
      endfunction

      task check_field(string name, logic [19:0] got, logic [19:0] want);
         if (got !== want)
            report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      endtask

      task check_result(plan_type got);
         plan_type want;
         if (pending_plans.size() == 0) begin
            report("result beat with nothing expected");
         end else begin
            want = pending_plans.pop_front();
            plans_checked++;
            check_field("freq_changed", 20'(got.freq_changed), 20'(want.freq_changed));
            check_field("out_enabled",  20'(got.out_enabled),  20'(want.out_enabled));
            check_field("pll_written",  20'(got.pll_written),  20'(want.pll_written));
            check_field("pll_p1",       20'(got.pll_p1),       20'(want.pll_p1));
            check_field("pll_p2",       got.pll_p2,            want.pll_p2);
            check_field("ms_written",   20'(got.ms_written),   20'(want.ms_written));
            check_field("ms_p1",        20'(got.ms_p1),        20'(want.ms_p1));
            check_field("r_div",        20'(got.r_div),        20'(want.r_div));
            check_field("ctrl_written", 20'(got.ctrl_written), 20'(want.ctrl_written));
            check_field("ctrl_byte",    20'(got.ctrl_byte),    20'(want.ctrl_byte));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [27:0] req_target_freq = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_freq_changed, rsp_out_enabled, rsp_pll_written;
   logic [17:0] rsp_pll_p1;
   logic [19:0] rsp_pll_p2;
   logic        rsp_ms_written;
   logic [15:0] rsp_ms_p1;
   logic [4:0]  rsp_r_div;
   logic        rsp_ctrl_written;
   logic [7:0]  rsp_ctrl_byte;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = csfp_pkg::CSR_XTAL;
   logic [25:0] csr_write_data = '0;

   plan_scoreboard plans = new();
   int          cycles = 0;
   int          requests_sent = 0;
   int          settings_used = 0;
   logic [27:0] last_sent = '0;

   clock_synth_frequency_planner i_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_target_freq,
      .rsp_valid, .rsp_stall,
      .rsp_freq_changed, .rsp_out_enabled, .rsp_pll_written,
      .rsp_pll_p1, .rsp_pll_p2, .rsp_ms_written, .rsp_ms_p1, .rsp_r_div,
      .rsp_ctrl_written, .rsp_ctrl_byte,
      .csr_write_enable, .csr_index, .csr_write_data
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
   end

   // monitor: register writes, accepted requests and result beats
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) plans.write_reg(csr_index, csr_write_data);
         if (req_valid && !req_stall) plans.note_request(req_target_freq);
         if (rsp_valid && !rsp_stall)
            plans.check_result({rsp_freq_changed, rsp_out_enabled, rsp_pll_written,
                                rsp_pll_p1, rsp_pll_p2, rsp_ms_written, rsp_ms_p1,
                                rsp_r_div, rsp_ctrl_written, rsp_ctrl_byte});
      end
   end

   // receiver backpressure: quiet, random and long-stall stretches
   int stall_mode = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(50, 2000);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ($urandom_range(0, 15) != 0);
      endcase
   end

   task write_reg(logic index, logic [25:0] data);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // one beat; valid stays high so the caller may chain the next one
   task send_request(logic [27:0] freq);
      req_valid = 1'b1;
      req_target_freq = freq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      requests_sent++;
      last_sent = freq;
   endtask

   task pause_sender();
      req_valid = 1'b0;
      repeat ($urandom_range(1, 300)) @(negedge clock);
   endtask

   task drain_results();
      req_valid = 1'b0;
      while (plans.pending_plans.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   function logic [27:0] pick_freq();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 28'($urandom_range(8000, 150000000));
      else if (pick < 60) return last_sent;
      else if (pick < 70) return 28'($urandom);
      else if (pick < 75) return 28'($urandom_range(150000001, 268435455));
      else if (pick < 78) return 28'd0;
      else if (pick < 88) return 28'($urandom_range(1, 8000));
      else return 28'($urandom_range(2900000, 3100000));
   endfunction

   task random_burst(int count);
      int in_burst;
      in_burst = 0;
      for (int n = 0; n < count; n++) begin
         if (in_burst == 0) begin
            if ($urandom_range(0, 3) != 0) pause_sender();
            in_burst = $urandom_range(1, 12);
         end
         send_request(pick_freq());
         in_burst--;
      end
   endtask

   logic [27:0] directed_freqs[] = '{
      28'd0, 28'd10000000, 28'd10000000, 28'd1, 28'd268435455, 28'd150000000,
      28'd150000001, 28'd3000000, 28'd2990000, 28'd2990001, 28'd0, 28'd0,
      28'd7000000, 28'd7000001, 28'd180000000, 28'd27000000, 28'd4096,
      28'd128000000, 28'd5555555, 28'd200000
   };

   logic [25:0] xtal_settings[] = '{
      26'd25000000, 26'd1000000, 26'd60000000, 26'd0, 26'h3FFFFFF, 26'd27000000
   };

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;
      foreach (directed_freqs[k]) send_request(directed_freqs[k]);
      drain_results();
      foreach (xtal_settings[k]) begin
         write_reg(csfp_pkg::CSR_XTAL, xtal_settings[k]);
         write_reg(csfp_pkg::CSR_DRIVE, 26'(k % 4));
         settings_used++;
         // a change of drive only shows once the divider moves, so force one
         send_request(28'd1000000 + 28'(k));
         random_burst(112);
         drain_results();
      end
      $display("%0d requests over %0d register settings, %0d result beats checked",
               requests_sent, settings_used, plans.plans_checked);
      $display("%0d mismatches", plans.mismatches);
      if (plans.mismatches == 0 && plans.pending_plans.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
